[rtl/ectg_pkg.sv]
// ----------------------------------------------------------------------------
// ectg_pkg
// Shared types and curve codes of the easing table generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ectg_pkg;

    typedef logic [3:0] t_curve;

    localparam t_curve CURVE_QUAD_IN      = 4'd0;
    localparam t_curve CURVE_QUAD_OUT     = 4'd1;
    localparam t_curve CURVE_QUAD_INOUT   = 4'd2;
    localparam t_curve CURVE_CUBIC_IN     = 4'd3;
    localparam t_curve CURVE_CUBIC_OUT    = 4'd4;
    localparam t_curve CURVE_CUBIC_INOUT  = 4'd5;
    localparam t_curve CURVE_QUINT_IN     = 4'd6;
    localparam t_curve CURVE_QUINT_OUT    = 4'd7;
    localparam t_curve CURVE_QUINT_INOUT  = 4'd8;
    localparam t_curve CURVE_BOUNCE_IN    = 4'd9;
    localparam t_curve CURVE_BOUNCE_OUT   = 4'd10;
    localparam t_curve CURVE_BOUNCE_INOUT = 4'd11;

    typedef logic [1:0] t_reg_idx;

    localparam t_reg_idx REG_CURVE = 2'd0;
    localparam t_reg_idx REG_START = 2'd1;
    localparam t_reg_idx REG_END   = 2'd2;
    localparam t_reg_idx REG_STEPS = 2'd3;

    typedef struct packed {
        logic valid;
        logic last;
    } t_tag;

endpackage

`default_nettype wire

[rtl/easing_curve_table_generator.sv]
// ----------------------------------------------------------------------------
// easing_curve_table_generator
// One eased table byte per step index, curve and range set over APB.
//
// Input: a step index is taken at each clock edge with i_start high and
// o_busy low. o_busy stays low, so an index can enter every cycle.
// Output: o_valid strobes for one cycle with o_table_byte and o_is_last,
// in the order of the inputs. Throughput is one byte per clock.
// The pipeline is the input register, the divider for the curve position,
// which resolves one quotient bit a stage, then six curve stages, the
// scale multiply and the output register.
// Configuration: APB registers curve_type, start_value, end_value and
// step_count at byte addresses 0, 4, 8 and 12. The user must write them
// only while idle; the block itself does not enforce this.
// Reset clears the pipeline valid bits and loads the register defaults.
// The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
`default_nettype none

module easing_curve_table_generator #(
    parameter int FRAC_BITS = 24,
    parameter int MAX_STEPS = 255
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [7:0]  i_step_index,
    output logic             o_valid,
    output logic [7:0]       o_table_byte,
    output logic             o_is_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int W = FRAC_BITS + 4;
    localparam int PW = W + 9;

    ectg_pkg::t_curve r_curve;
    logic [7:0]       r_start, r_end, r_steps;

    ectg_pkg::t_reg_idx reg_idx;
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve <= ectg_pkg::CURVE_QUAD_IN;
            r_start <= 8'd0;
            r_end   <= 8'd16;
            r_steps <= 8'd16;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                ectg_pkg::REG_CURVE: r_curve <= pwdata[3:0];
                ectg_pkg::REG_START: r_start <= pwdata[7:0];
                ectg_pkg::REG_END:   r_end   <= pwdata[7:0];
                ectg_pkg::REG_STEPS: r_steps <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ectg_pkg::REG_CURVE: prdata = {28'd0, r_curve};
            ectg_pkg::REG_START: prdata = {24'd0, r_start};
            ectg_pkg::REG_END:   prdata = {24'd0, r_end};
            ectg_pkg::REG_STEPS: prdata = {24'd0, r_steps};
            default:             prdata = '0;
        endcase
    end

    // effective range
    logic [7:0] n_cnt, den, diff, base;
    logic       rising;

    always_comb begin
        if (r_steps < 8'd2) begin
            n_cnt = 8'd2;
        end else if (r_steps > 8'(MAX_STEPS)) begin
            n_cnt = 8'(MAX_STEPS);
        end else begin
            n_cnt = r_steps;
        end
        den    = n_cnt - 8'd1;
        rising = (r_end > r_start);
        diff   = rising ? r_end - r_start : r_start - r_end;
        base   = rising ? r_start : r_end;
    end

    assign o_busy = 1'b0;

    // input stage
    logic [7:0]     n_k;
    ectg_pkg::t_tag r_in_tag;
    logic [7:0]     r_pos;

    assign n_k = (i_step_index > den) ? den : i_step_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tag <= '0;
        end else begin
            r_in_tag.valid <= i_start && !o_busy;
            r_in_tag.last  <= (i_step_index == den);
        end
        r_pos <= rising ? n_k : den - n_k;
    end

    ectg_pkg::t_tag     div_tag;
    logic [FRAC_BITS:0] div_t;

    ectg_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_in_tag),
        .i_pos   (r_pos),
        .i_den   (den),
        .o_tag   (div_tag),
        .o_quo   (div_t)
    );

    ectg_pkg::t_tag      ease_tag;
    logic signed [W-1:0] ease_f;

    ectg_ease #(.FRAC_BITS(FRAC_BITS)) u_ease (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_curve (r_curve),
        .i_tag   (div_tag),
        .i_t     (div_t),
        .o_tag   (ease_tag),
        .o_f     (ease_f)
    );

    // scale and output
    ectg_pkg::t_tag       r_sc_tag;
    logic signed [PW-1:0] r_sc;
    logic [PW-1:0]        n_mag;
    logic [PW-1:0]        n_sc;

    always_comb begin
        n_mag = r_sc[PW-1] ? PW'(-r_sc) : PW'(r_sc);
        n_mag = n_mag >> FRAC_BITS;
        n_sc  = r_sc[PW-1] ? PW'(-n_mag) : n_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_tag  <= '0;
            o_valid   <= 1'b0;
            o_is_last <= 1'b0;
        end else begin
            r_sc_tag  <= ease_tag;
            o_valid   <= r_sc_tag.valid;
            o_is_last <= r_sc_tag.valid && r_sc_tag.last;
        end
        r_sc         <= PW'(ease_f) * $signed({1'b0, diff});
        o_table_byte <= n_sc[7:0] + base;
    end

endmodule

`default_nettype wire

[rtl/ectg_div.sv]
// ----------------------------------------------------------------------------
// ectg_div
// Pipelined restoring divider: t = pos * 2^FRAC_BITS / den, one bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ectg_div #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ectg_pkg::t_tag    i_tag,
    input  wire logic [7:0]        i_pos,
    input  wire logic [7:0]        i_den,
    output ectg_pkg::t_tag         o_tag,
    output logic [FRAC_BITS:0]     o_quo
);

    logic [7:0]           r_rem [0:FRAC_BITS];
    logic [FRAC_BITS:0]   r_quo [0:FRAC_BITS];
    ectg_pkg::t_tag       r_tag [0:FRAC_BITS];

    logic                 n_q0;
    logic [7:0]           n_rem0;

    always_comb begin
        n_q0   = (i_pos >= i_den);
        n_rem0 = n_q0 ? (i_pos - i_den) : i_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0] <= '0;
        end else begin
            r_tag[0] <= i_tag;
        end
        r_rem[0] <= n_rem0;
        r_quo[0] <= {{FRAC_BITS{1'b0}}, n_q0};
    end

    for (genvar j = 1; j <= FRAC_BITS; j++) begin : g_stage
        logic [8:0] n_r2;
        logic [8:0] n_den9;
        logic       n_ge;

        always_comb begin
            n_r2   = {r_rem[j-1], 1'b0};
            n_den9 = {1'b0, i_den};
            n_ge   = (n_r2 >= n_den9);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[j] <= '0;
            end else begin
                r_tag[j] <= r_tag[j-1];
            end
            r_rem[j] <= n_ge ? 8'(n_r2 - n_den9) : n_r2[7:0];
            r_quo[j] <= {r_quo[j-1][FRAC_BITS-1:0], n_ge};
        end
    end

    assign o_tag = r_tag[FRAC_BITS];
    assign o_quo = r_quo[FRAC_BITS];

endmodule

`default_nettype wire

[rtl/ectg_ease.sv]
// ----------------------------------------------------------------------------
// ectg_ease
// Six-stage curve pipeline: curve argument, operands and bounce segment,
// three fixed-point multiplies and the final combine.
// ----------------------------------------------------------------------------
`default_nettype none

module ectg_ease #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ectg_pkg::t_curve            i_curve,
    input  wire ectg_pkg::t_tag              i_tag,
    input  wire logic [FRAC_BITS:0]          i_t,
    output ectg_pkg::t_tag                   o_tag,
    output logic signed [FRAC_BITS+3:0]      o_f
);

    localparam int W = FRAC_BITS + 4;
    localparam longint ONE_L = longint'(1) << FRAC_BITS;

    localparam logic signed [W-1:0] ONE   = W'(ONE_L);
    localparam logic signed [W-1:0] TWO   = W'(2 * ONE_L);
    localparam logic signed [W-1:0] MAGIC = W'((121 * ONE_L) / 16);
    localparam logic signed [W-1:0] TH4   = W'((4 * ONE_L) / 11);
    localparam logic signed [W-1:0] TH8   = W'((8 * ONE_L) / 11);
    localparam logic signed [W-1:0] TH10  = W'((10 * ONE_L) / 11);
    localparam logic signed [W-1:0] OFS6  = W'((6 * ONE_L) / 11);
    localparam logic signed [W-1:0] OFS9  = W'((9 * ONE_L) / 11);
    localparam logic signed [W-1:0] OFS21 = W'((21 * ONE_L) / 22);
    localparam logic signed [W-1:0] ADD3  = W'((3 * ONE_L) / 4);
    localparam logic signed [W-1:0] ADD15 = W'((15 * ONE_L) / 16);
    localparam logic signed [W-1:0] ADD63 = W'((63 * ONE_L) / 64);
    localparam logic signed [W-1:0] HALF1 = W'(ONE_L / 2);

    function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [2*W-1:0] p;
        logic [2*W-1:0]        m;
        p = a * b;
        m = p[2*W-1] ? (2*W)'(-p) : (2*W)'(p);
        m = m >> FRAC_BITS;
        return p[2*W-1] ? W'(-m) : W'(m);
    endfunction

    function automatic logic signed [W-1:0] qhalf(input logic signed [W-1:0] a);
        logic signed [W-1:0] s;
        s = a + W'(a[W-1]);
        return s >>> 1;
    endfunction

    ectg_pkg::t_curve c;
    assign c = (i_curve > ectg_pkg::CURVE_BOUNCE_INOUT) ? ectg_pkg::CURVE_QUAD_IN : i_curve;

    ectg_pkg::t_tag r_tag [1:6];

    // stage 1: curve argument
    logic signed [W-1:0] n_t, n_nt, n_x;
    logic                n_lo;
    logic signed [W-1:0] r1_x;
    logic                r1_lo;

    always_comb begin
        n_t  = W'($signed({1'b0, i_t}));
        n_nt = n_t <<< 1;
        n_lo = (n_nt < ONE);
        case (c)
            ectg_pkg::CURVE_QUAD_INOUT:   n_x = n_lo ? n_nt : n_nt - ONE;
            ectg_pkg::CURVE_CUBIC_OUT,
            ectg_pkg::CURVE_QUINT_OUT:    n_x = n_t - ONE;
            ectg_pkg::CURVE_CUBIC_INOUT,
            ectg_pkg::CURVE_QUINT_INOUT:  n_x = n_lo ? n_nt : n_nt - TWO;
            ectg_pkg::CURVE_BOUNCE_IN:    n_x = ONE - n_t;
            ectg_pkg::CURVE_BOUNCE_INOUT: n_x = n_lo ? ONE - n_nt : n_nt - ONE;
            default:                      n_x = n_t;
        endcase
    end

    // stage 2: operands and bounce segment
    logic signed [W-1:0] n_a, n_b, n_u, n_add;
    logic signed [W-1:0] r2_a, r2_b, r2_x, r2_u, r2_add;
    logic                r2_lo;

    always_comb begin
        if (r1_x < TH4) begin
            n_u = r1_x;          n_add = '0;
        end else if (r1_x < TH8) begin
            n_u = r1_x - OFS6;   n_add = ADD3;
        end else if (r1_x < TH10) begin
            n_u = r1_x - OFS9;   n_add = ADD15;
        end else begin
            n_u = r1_x - OFS21;  n_add = ADD63;
        end
        n_a = r1_x;
        n_b = r1_x;
        case (c)
            ectg_pkg::CURVE_QUAD_OUT:   n_b = TWO - r1_x;
            ectg_pkg::CURVE_QUAD_INOUT: n_b = r1_lo ? r1_x : r1_x - TWO;
            ectg_pkg::CURVE_BOUNCE_IN,
            ectg_pkg::CURVE_BOUNCE_OUT,
            ectg_pkg::CURVE_BOUNCE_INOUT: begin
                n_a = MAGIC;
                n_b = n_u;
            end
            default: ;
        endcase
    end

    // stages 3 to 5: multiplies
    logic signed [W-1:0] r3_p, r3_x, r3_u, r3_add;
    logic                r3_lo;
    logic signed [W-1:0] n_m2;
    logic signed [W-1:0] r4_p, r4_x, r4_add;
    logic                r4_lo;
    logic signed [W-1:0] n_m3;
    logic signed [W-1:0] r5_p, r5_add;
    logic                r5_lo;

    always_comb begin
        case (c)
            ectg_pkg::CURVE_CUBIC_IN,
            ectg_pkg::CURVE_CUBIC_OUT,
            ectg_pkg::CURVE_CUBIC_INOUT:  n_m2 = qmul(r3_p, r3_x);
            ectg_pkg::CURVE_QUINT_IN,
            ectg_pkg::CURVE_QUINT_OUT,
            ectg_pkg::CURVE_QUINT_INOUT:  n_m2 = qmul(r3_p, r3_p);
            ectg_pkg::CURVE_BOUNCE_IN,
            ectg_pkg::CURVE_BOUNCE_OUT,
            ectg_pkg::CURVE_BOUNCE_INOUT: n_m2 = qmul(r3_p, r3_u);
            default:                      n_m2 = r3_p;
        endcase
        case (c)
            ectg_pkg::CURVE_QUINT_IN,
            ectg_pkg::CURVE_QUINT_OUT,
            ectg_pkg::CURVE_QUINT_INOUT:  n_m3 = qmul(r4_p, r4_x);
            default:                      n_m3 = r4_p;
        endcase
    end

    // stage 6: combine
    logic signed [W-1:0] n_f, n_bo;
    logic signed [W-1:0] r6_f;

    always_comb begin
        n_bo = r5_p + r5_add;
        case (c)
            ectg_pkg::CURVE_QUAD_INOUT:   n_f = r5_lo ? qhalf(r5_p) : qhalf(ONE - r5_p);
            ectg_pkg::CURVE_CUBIC_OUT,
            ectg_pkg::CURVE_QUINT_OUT:    n_f = r5_p + ONE;
            ectg_pkg::CURVE_CUBIC_INOUT,
            ectg_pkg::CURVE_QUINT_INOUT:  n_f = r5_lo ? qhalf(r5_p) : qhalf(r5_p + TWO);
            ectg_pkg::CURVE_BOUNCE_IN:    n_f = ONE - n_bo;
            ectg_pkg::CURVE_BOUNCE_OUT:   n_f = n_bo;
            ectg_pkg::CURVE_BOUNCE_INOUT: n_f = r5_lo ? qhalf(ONE - n_bo)
                                                      : qhalf(n_bo) + HALF1;
            default:                      n_f = r5_p;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= 6; i++) begin
                r_tag[i] <= '0;
            end
        end else begin
            r_tag[1] <= i_tag;
            for (int i = 2; i <= 6; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
        end
        r1_x   <= n_x;
        r1_lo  <= n_lo;
        r2_a   <= n_a;
        r2_b   <= n_b;
        r2_x   <= r1_x;
        r2_u   <= n_u;
        r2_add <= n_add;
        r2_lo  <= r1_lo;
        r3_p   <= qmul(r2_a, r2_b);
        r3_x   <= r2_x;
        r3_u   <= r2_u;
        r3_add <= r2_add;
        r3_lo  <= r2_lo;
        r4_p   <= n_m2;
        r4_x   <= r3_x;
        r4_add <= r3_add;
        r4_lo  <= r3_lo;
        r5_p   <= n_m3;
        r5_add <= r4_add;
        r5_lo  <= r4_lo;
        r6_f   <= n_f;
    end

    assign o_tag = r_tag[6];
    assign o_f   = r6_f;

endmodule

`default_nettype wire

[rtl/ectg_checker.sv]
// ----------------------------------------------------------------------------
// ectg_checker
// Port-level checks of the easing table generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ectg_checker #(
    parameter int FRAC_BITS = 24
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_start,
    input wire logic o_busy,
    input wire logic o_valid,
    input wire logic o_is_last
);

    localparam int LAT = FRAC_BITS + 10;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !o_busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_valid)
        else $error("result beat missing");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, LAT))
        else $error("result beat without input beat");

    a_last_gated: assert property (@(posedge i_clk) o_is_last |-> o_valid)
        else $error("is_last without valid");

endmodule

bind easing_curve_table_generator ectg_checker #(.FRAC_BITS(FRAC_BITS)) u_ectg_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_start   (i_start),
    .o_busy    (o_busy),
    .o_valid   (o_valid),
    .o_is_last (o_is_last)
);

`default_nettype wire

[test/easing_curve_table_checker.sv]
// ----------------------------------------------------------------------------
// easing_curve_table_checker
// Watches the index, result and APB channels of the easing table generator.
// Keeps its own copy of the registers, works out the expected table byte and
// last flag for every accepted index, and compares each result beat in order.
// ----------------------------------------------------------------------------
`default_nettype none

module easing_curve_table_checker #(
    parameter int FRAC_BITS = 24,
    parameter int MAX_STEPS = 255
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic [7:0]  i_step_index,
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_table_byte,
    input  wire logic        i_is_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_results
);

    localparam longint ONE = longint'(1) << FRAC_BITS;

    typedef struct packed {
        logic [7:0] table_byte;
        logic       is_last;
    } t_entry;

    ectg_pkg::t_curve curve_q;
    logic [7:0]       start_q;
    logic [7:0]       end_q;
    logic [7:0]       steps_q;
    t_entry           expected_bytes[$];

    function automatic longint fx_mul(longint a, longint b);
        longint p;
        p = a * b;
        if (p < 0) return -((-p) >>> FRAC_BITS);
        return p >>> FRAC_BITS;
    endfunction

    function automatic longint fx_ratio(longint num, longint den);
        return (num * ONE) / den;
    endfunction

    function automatic longint fx_cube(longint x);
        return fx_mul(fx_mul(x, x), x);
    endfunction

    function automatic longint fx_fifth(longint x);
        longint x2;
        x2 = fx_mul(x, x);
        return fx_mul(fx_mul(x2, x2), x);
    endfunction

    function automatic longint bounce_tail(longint t);
        longint u;
        longint add;
        if (t < fx_ratio(4, 11)) begin
            u = t;
            add = 0;
        end else if (t < fx_ratio(8, 11)) begin
            u = t - fx_ratio(6, 11);
            add = fx_ratio(3, 4);
        end else if (t < fx_ratio(10, 11)) begin
            u = t - fx_ratio(9, 11);
            add = fx_ratio(15, 16);
        end else begin
            u = t - fx_ratio(21, 22);
            add = fx_ratio(63, 64);
        end
        return fx_mul(fx_mul(fx_ratio(121, 16), u), u) + add;
    endfunction

    function automatic longint bounce_head(longint t);
        return ONE - bounce_tail(ONE - t);
    endfunction

    function automatic longint eased_position(ectg_pkg::t_curve curve, longint t);
        longint nt;
        longint lt;
        nt = 2 * t;
        case (curve)
            ectg_pkg::CURVE_QUAD_OUT: return fx_mul(t, 2 * ONE - t);
            ectg_pkg::CURVE_QUAD_INOUT: begin
                if (nt < ONE) return fx_mul(nt, nt) / 2;
                lt = nt - ONE;
                return (-(fx_mul(lt, lt - 2 * ONE) - ONE)) / 2;
            end
            ectg_pkg::CURVE_CUBIC_IN:  return fx_cube(t);
            ectg_pkg::CURVE_CUBIC_OUT: return fx_cube(t - ONE) + ONE;
            ectg_pkg::CURVE_CUBIC_INOUT: begin
                if (nt < ONE) return fx_cube(nt) / 2;
                return (fx_cube(nt - 2 * ONE) + 2 * ONE) / 2;
            end
            ectg_pkg::CURVE_QUINT_IN:  return fx_fifth(t);
            ectg_pkg::CURVE_QUINT_OUT: return fx_fifth(t - ONE) + ONE;
            ectg_pkg::CURVE_QUINT_INOUT: begin
                if (nt < ONE) return fx_fifth(nt) / 2;
                return (fx_fifth(nt - 2 * ONE) + 2 * ONE) / 2;
            end
            ectg_pkg::CURVE_BOUNCE_IN:  return bounce_head(t);
            ectg_pkg::CURVE_BOUNCE_OUT: return bounce_tail(t);
            ectg_pkg::CURVE_BOUNCE_INOUT: begin
                if (t < ONE / 2) return bounce_head(nt) / 2;
                return bounce_tail(nt - ONE) / 2 + ONE / 2;
            end
            default: return fx_mul(t, t);
        endcase
    endfunction

    function automatic t_entry table_entry(logic [7:0] raw);
        t_entry e;
        longint n;
        longint k;
        longint pos;
        longint diff;
        longint base;
        longint scaled;
        n = steps_q;
        if (n < 2) n = 2;
        if (n > MAX_STEPS) n = MAX_STEPS;
        k = raw;
        if (k > n - 1) k = n - 1;
        if (end_q > start_q) begin
            pos = k;
            diff = end_q - start_q;
            base = start_q;
        end else begin
            pos = n - 1 - k;
            diff = start_q - end_q;
            base = end_q;
        end
        scaled = eased_position(curve_q, fx_ratio(pos, n - 1)) * diff;
        if (scaled < 0) scaled = -((-scaled) >>> FRAC_BITS);
        else scaled = scaled >>> FRAC_BITS;
        e.table_byte = 8'(scaled + base);
        e.is_last = (longint'(raw) == n - 1);
        return e;
    endfunction

    always_ff @(posedge i_clk) begin
        t_entry e;
        if (!i_rst_n) begin
            curve_q <= ectg_pkg::CURVE_QUAD_IN;
            start_q <= 8'd0;
            end_q <= 8'd16;
            steps_q <= 8'd16;
            expected_bytes.delete();
            o_fail_count <= 0;
            o_results <= 0;
            o_pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
                case (ectg_pkg::t_reg_idx'(paddr[3:2]))
                    ectg_pkg::REG_CURVE: curve_q <= ectg_pkg::t_curve'(pwdata[3:0]);
                    ectg_pkg::REG_START: start_q <= pwdata[7:0];
                    ectg_pkg::REG_END:   end_q <= pwdata[7:0];
                    ectg_pkg::REG_STEPS: steps_q <= pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_valid) begin
                o_results <= o_results + 1;
                if (expected_bytes.size() == 0) begin
                    $error("result beat with nothing expected: byte %0d last %0b",
                           i_table_byte, i_is_last);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_bytes.pop_front();
                    if (e.table_byte !== i_table_byte || e.is_last !== i_is_last) begin
                        if (e.table_byte !== i_table_byte)
                            $error("table_byte: expected %0d, got %0d",
                                   e.table_byte, i_table_byte);
                        if (e.is_last !== i_is_last)
                            $error("is_last: expected %0b, got %0b", e.is_last, i_is_last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) expected_bytes.push_back(table_entry(i_step_index));
            o_pending <= expected_bytes.size();
        end
    end

endmodule

`default_nettype wire

[test/easing_curve_table_generator_test.sv]
// ----------------------------------------------------------------------------
// easing_curve_table_generator_test
// Drives step indices and APB register writes into the easing table
// generator across many curve, range and step count settings, with idle
// gaps on the index side, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module easing_curve_table_generator_test;

    localparam int LATENCY = 34;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [7:0]  i_step_index = 8'd0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic        o_busy;
    logic        o_valid;
    logic [7:0]  o_table_byte;
    logic        o_is_last;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          results;
    int          quiet_cycles = 0;
    int          sent = 0;
    int          idle_pct = 0;

    always #5 i_clk = ~i_clk;

    easing_curve_table_generator uut (
        .i_clk, .i_rst_n, .i_start, .o_busy, .i_step_index,
        .o_valid, .o_table_byte, .o_is_last,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    easing_curve_table_checker checker_i (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_step_index,
        .i_valid(o_valid), .i_table_byte(o_table_byte), .i_is_last(o_is_last),
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .o_fail_count(fail_count), .o_pending(pending), .o_results(results)
    );

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(ectg_pkg::t_reg_idx idx, logic [31:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic drain();
        i_start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic configure(ectg_pkg::t_curve curve, logic [7:0] first, logic [7:0] last,
                             logic [7:0] steps);
        write_reg(ectg_pkg::REG_CURVE, 32'(curve));
        write_reg(ectg_pkg::REG_START, 32'(first));
        write_reg(ectg_pkg::REG_END, 32'(last));
        write_reg(ectg_pkg::REG_STEPS, 32'(steps));
    endtask

    task automatic send_index(logic [7:0] idx);
        while ($urandom_range(99) < idle_pct) begin
            i_start = 1'b0;
            @(negedge i_clk);
        end
        i_start = 1'b1;
        i_step_index = idx;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    initial begin
        int n;
        logic [7:0] steps;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // defaults after reset, then the extremes of range and step count
        send_index(8'd0);
        send_index(8'd15);
        send_index(8'd255);
        drain();
        configure(ectg_pkg::CURVE_QUAD_IN, 8'd0, 8'd255, 8'd255);
        send_index(8'd0);
        send_index(8'd1);
        send_index(8'd127);
        send_index(8'd253);
        send_index(8'd254);
        send_index(8'd255);
        drain();
        configure(ectg_pkg::CURVE_BOUNCE_INOUT, 8'd255, 8'd0, 8'd0);
        send_index(8'd0);
        send_index(8'd1);
        send_index(8'd200);
        drain();
        configure(ectg_pkg::t_curve'(4'd15), 8'd77, 8'd77, 8'd1);
        send_index(8'd0);
        send_index(8'd1);
        send_index(8'd170);
        drain();
        for (int c = 0; c < 12; c++) begin
            configure(ectg_pkg::t_curve'(c), 8'(c * 20), 8'(250 - c * 21), 8'd3);
            send_index(8'd0);
            send_index(8'd1);
            drain();
        end

        for (int p = 0; p < PHASES; p++) begin
            idle_pct = (p < PHASES / 3) ? 23 : (p < 2 * PHASES / 3) ? 51 : 0;
            steps = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                             : 8'($urandom_range(2, 24));
            if (p == 0) steps = 8'd255;
            configure(ectg_pkg::t_curve'($urandom_range(15)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), steps);
            n = (steps < 2) ? 2 : steps;
            repeat (21) begin
                if ($urandom_range(9) == 0) send_index(8'($urandom_range(255)));
                else send_index(8'($urandom_range(n - 1)));
            end
            drain();
        end

        $display("covered %0d step indices and %0d table bytes over %0d settings,",
                 sent, results, PHASES + 16);
        $display("all twelve curves plus unknown codes, both range directions");
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
